// ===== hw/rtl/bidirectional_index_matching_table_unit_macros.svh =====
// Assertion macros shared by the matching table RTL.
`ifndef BIDIRECTIONAL_INDEX_MATCHING_TABLE_UNIT_MACROS_SVH
`define BIDIRECTIONAL_INDEX_MATCHING_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define BIMT_ASSERT_NOW(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define BIMT_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== hw/rtl/bimt_pkg.sv =====
// Types and constants of the bidirectional index matching table.
package bimt_pkg;

    // Width of one index as it travels on the request and result channels.
    localparam int IDX_W = 6;

    // Width of the size registers and their value after reset.
    localparam int SIZE_W = 7;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_SIZE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_SIZE = 1'b1;

    // Packed widths of the stream payloads.
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 8;

    // Operation codes; the fourth code is a no-operation.
    typedef enum logic [1:0] {
        OP_SET   = 2'd0,
        OP_UNSET = 2'd1,
        OP_GET   = 2'd2
    } op_t;

    // Key direction.
    localparam logic DIR_LEFT  = 1'b0;
    localparam logic DIR_RIGHT = 1'b1;

endpackage

// ===== hw/rtl/bimt_ram.sv =====
// Generic single-write, single-read RAM with a registered, read-first read port.
module bimt_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // A read at the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/bidirectional_index_matching_table_unit.sv =====
// Top level of the bidirectional index matching table.
//
//   Channel  Direction  Payload
//   s_axis   in         request: opcode, direction, key, partner
//   m_axis   out        result: found, mapped_index, range_error
//   cfg      in         size register writes (left_size, right_size)
//
// A request enters the working stage at the edge where it is accepted, and its result is
// loaded into the result register when the working stage moves on. One request per cycle
// is taken while the result side keeps up. Table reads start as the request is accepted
// and updates are written as it leaves the working stage; a one-entry bypass covers a read
// of the address being written. Reset clears all valid bits at once, with no clearing pass.
// A stalled result holds a full working stage, s_axis_tready low and the tables unchanged.
module bidirectional_index_matching_table_unit
    import bimt_pkg::*;
#(
    parameter int LEFT_DEPTH  = 64,
    parameter int RIGHT_DEPTH = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // Bits from 0: opcode[1:0], direction[2], key[8:3], partner[14:9], zero[15].
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // Bits from 0: found[0], mapped_index[6:1], range_error[7].
    output logic [OUT_DATA_W-1:0] m_axis_tdata,

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [SIZE_W-1:0]     cfg_wdata
);

    `include "bidirectional_index_matching_table_unit_macros.svh"

    // Address widths of the two tables, and widths wide enough to hold either a
    // table address or a request index, used to convert one into the other.
    localparam int LAW = $clog2(LEFT_DEPTH);
    localparam int RAW = $clog2(RIGHT_DEPTH);
    localparam int LXW = (LAW > IDX_W) ? LAW : IDX_W;
    localparam int RXW = (RAW > IDX_W) ? RAW : IDX_W;

    // Configuration registers.
    logic [SIZE_W-1:0] left_size_reg;
    logic [SIZE_W-1:0] right_size_reg;

    // Working stage: the request whose table reads are in flight.
    logic             s1_valid_reg;
    op_t              s1_op_reg;
    logic             s1_dir_reg;
    logic [IDX_W-1:0] s1_key_reg;
    logic [IDX_W-1:0] s1_partner_reg;

    // Result register.
    logic             out_valid_reg;
    logic             out_found_reg;
    logic [IDX_W-1:0] out_mapped_reg;
    logic             out_err_reg;

    // Valid bits of both tables; the partner indexes live in the RAMs.
    logic [LEFT_DEPTH-1:0]  lvalid_reg;
    logic [LEFT_DEPTH-1:0]  lvalid_next;
    logic [RIGHT_DEPTH-1:0] rvalid_reg;
    logic [RIGHT_DEPTH-1:0] rvalid_next;

    // Bypass for a table write that hit the address read in the same cycle.
    logic             l_byp_hit_reg;
    logic [IDX_W-1:0] l_byp_data_reg;
    logic             r_byp_hit_reg;
    logic [IDX_W-1:0] r_byp_data_reg;

    // Handshake.
    logic in_fire;
    logic s1_go;

    // Request fields and table read addresses at the input.
    op_t              in_op;
    logic [IDX_W-1:0] in_key;
    logic [IDX_W-1:0] in_partner;
    logic [LXW-1:0]   in_key_lx;
    logic [RXW-1:0]   in_rsel_rx;
    logic [LAW-1:0]   l_raddr_in;
    logic [RAW-1:0]   r_raddr_in;

    // RAM ports.
    logic [IDX_W-1:0] l_rdata;
    logic [IDX_W-1:0] r_rdata;
    logic             l_we;
    logic [LAW-1:0]   l_waddr;
    logic [IDX_W-1:0] l_wdata;
    logic             r_we;
    logic [RAW-1:0]   r_waddr;
    logic [IDX_W-1:0] r_wdata;

    // Working stage decode.
    logic [IDX_W-1:0] l_rd;
    logic [IDX_W-1:0] r_rd;
    logic [LXW-1:0]   key_lx;
    logic [RXW-1:0]   key_rx;
    logic [RXW-1:0]   partner_rx;
    logic [RXW-1:0]   l_rd_rx;
    logic [LXW-1:0]   r_rd_lx;
    logic [LAW-1:0]   k_l;
    logic [RAW-1:0]   k_r;
    logic [RAW-1:0]   p_r;
    logic [RAW-1:0]   l_rd_r;
    logic [LAW-1:0]   r_rd_l;
    logic [RAW-1:0]   s1_rsel;
    logic             lv_key;
    logic             rv_sel;
    logic             key_in_left;
    logic             key_in_right;
    logic             partner_in_right;
    logic             key_bad;

    // Table updates and result of the working stage.
    logic             l_clr_en;
    logic [LAW-1:0]   l_clr_addr;
    logic             r_clr_en;
    logic [RAW-1:0]   r_clr_addr;
    logic             res_found;
    logic [IDX_W-1:0] res_mapped;
    logic             res_err;

    // ------------------------------------------------------------------
    // Handshake: a new request enters whenever the working stage is empty or
    // moves on into the result register in the same cycle.
    // ------------------------------------------------------------------
    assign s1_go         = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_go;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_err_reg, out_mapped_reg, out_found_reg};

    // ------------------------------------------------------------------
    // Read addresses at the input. The right table is read at the partner for
    // a set and at the key otherwise; the left table always at the key.
    // ------------------------------------------------------------------
    assign in_op      = op_t'(s_axis_tdata[1:0]);
    assign in_key     = s_axis_tdata[8:3];
    assign in_partner = s_axis_tdata[14:9];
    assign in_key_lx  = LXW'(in_key);
    assign in_rsel_rx = RXW'((in_op == OP_SET) ? in_partner : in_key);
    assign l_raddr_in = in_key_lx[LAW-1:0];
    assign r_raddr_in = in_rsel_rx[RAW-1:0];

    // Left table: partner (right index) of each left index.
    bimt_ram #(
        .WIDTH (IDX_W),
        .DEPTH (LEFT_DEPTH)
    ) u_left_ram (
        .clk   (clk),
        .we    (l_we),
        .waddr (l_waddr),
        .wdata (l_wdata),
        .re    (in_fire),
        .raddr (l_raddr_in),
        .rdata (l_rdata)
    );

    // Right table: partner (left index) of each right index.
    bimt_ram #(
        .WIDTH (IDX_W),
        .DEPTH (RIGHT_DEPTH)
    ) u_right_ram (
        .clk   (clk),
        .we    (r_we),
        .waddr (r_waddr),
        .wdata (r_wdata),
        .re    (in_fire),
        .raddr (r_raddr_in),
        .rdata (r_rdata)
    );

    // ------------------------------------------------------------------
    // Working stage decode. A valid bit always comes with a correct index in
    // its RAM entry; the index of an entry that is not valid is never used.
    // ------------------------------------------------------------------
    assign l_rd = l_byp_hit_reg ? l_byp_data_reg : l_rdata;
    assign r_rd = r_byp_hit_reg ? r_byp_data_reg : r_rdata;

    assign key_lx     = LXW'(s1_key_reg);
    assign key_rx     = RXW'(s1_key_reg);
    assign partner_rx = RXW'(s1_partner_reg);
    assign l_rd_rx    = RXW'(l_rd);
    assign r_rd_lx    = LXW'(r_rd);
    assign k_l        = key_lx[LAW-1:0];
    assign k_r        = key_rx[RAW-1:0];
    assign p_r        = partner_rx[RAW-1:0];
    assign l_rd_r     = l_rd_rx[RAW-1:0];
    assign r_rd_l     = r_rd_lx[LAW-1:0];
    assign s1_rsel    = (s1_op_reg == OP_SET) ? p_r : k_r;

    assign lv_key = lvalid_reg[k_l];
    assign rv_sel = rvalid_reg[s1_rsel];

    // An index is in range when it is below both its size register and the
    // table depth.
    assign key_in_left      = ({1'b0, s1_key_reg} < left_size_reg)
                              && (int'(s1_key_reg) < LEFT_DEPTH);
    assign key_in_right     = ({1'b0, s1_key_reg} < right_size_reg)
                              && (int'(s1_key_reg) < RIGHT_DEPTH);
    assign partner_in_right = ({1'b0, s1_partner_reg} < right_size_reg)
                              && (int'(s1_partner_reg) < RIGHT_DEPTH);
    assign key_bad          = (s1_dir_reg == DIR_LEFT) ? !key_in_left : !key_in_right;

    always_comb
    begin
        l_we       = 1'b0;
        l_waddr    = k_l;
        l_wdata    = s1_partner_reg;
        r_we       = 1'b0;
        r_waddr    = p_r;
        r_wdata    = s1_key_reg;
        l_clr_en   = 1'b0;
        l_clr_addr = r_rd_l;
        r_clr_en   = 1'b0;
        r_clr_addr = l_rd_r;
        res_found  = 1'b0;
        res_mapped = '0;
        res_err    = 1'b0;
        case (s1_op_reg)
            OP_SET:
            begin
                res_err = !key_in_left || !partner_in_right;
                // Pairing an existing pair again changes nothing. Otherwise
                // the old partners of both indexes lose their entries and
                // the new pair is written into both tables.
                if (!res_err && !(lv_key && (l_rd == s1_partner_reg)))
                begin
                    r_clr_en   = lv_key;
                    r_clr_addr = l_rd_r;
                    l_clr_en   = rv_sel;
                    l_clr_addr = r_rd_l;
                    l_we       = 1'b1;
                    r_we       = 1'b1;
                end
            end
            OP_UNSET:
            begin
                res_err = key_bad;
                if (!res_err)
                begin
                    if (s1_dir_reg == DIR_LEFT)
                    begin
                        l_clr_en   = lv_key;
                        l_clr_addr = k_l;
                        r_clr_en   = lv_key;
                        r_clr_addr = l_rd_r;
                    end
                    else
                    begin
                        r_clr_en   = rv_sel;
                        r_clr_addr = k_r;
                        l_clr_en   = rv_sel;
                        l_clr_addr = r_rd_l;
                    end
                end
            end
            OP_GET:
            begin
                res_err = key_bad;
                if (!res_err)
                begin
                    if (s1_dir_reg == DIR_LEFT)
                    begin
                        res_found  = lv_key;
                        res_mapped = lv_key ? l_rd : '0;
                    end
                    else
                    begin
                        res_found  = rv_sel;
                        res_mapped = rv_sel ? r_rd : '0;
                    end
                end
            end
            default:
            begin
                // The unused code does nothing and reports all zeros.
                res_err = 1'b0;
            end
        endcase
        // Tables only change when the request moves on.
        l_we     = l_we && s1_go;
        r_we     = r_we && s1_go;
        l_clr_en = l_clr_en && s1_go;
        r_clr_en = r_clr_en && s1_go;
    end

    // Valid bits: a clear and a set per table; the set wins.
    always_comb
    begin
        for (int i = 0; i < LEFT_DEPTH; i++)
        begin
            lvalid_next[i] = lvalid_reg[i];
            if (l_clr_en && (l_clr_addr == LAW'(i)))
            begin
                lvalid_next[i] = 1'b0;
            end
            if (l_we && (l_waddr == LAW'(i)))
            begin
                lvalid_next[i] = 1'b1;
            end
        end
        for (int j = 0; j < RIGHT_DEPTH; j++)
        begin
            rvalid_next[j] = rvalid_reg[j];
            if (r_clr_en && (r_clr_addr == RAW'(j)))
            begin
                rvalid_next[j] = 1'b0;
            end
            if (r_we && (r_waddr == RAW'(j)))
            begin
                rvalid_next[j] = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Control registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_size_reg  <= SIZE_RESET;
            right_size_reg <= SIZE_RESET;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            lvalid_reg     <= '0;
            rvalid_reg     <= '0;
            l_byp_hit_reg  <= 1'b0;
            r_byp_hit_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_LEFT_SIZE:  left_size_reg  <= cfg_wdata;
                    REG_RIGHT_SIZE: right_size_reg <= cfg_wdata;
                    default:        left_size_reg  <= left_size_reg;
                endcase
            end
            if (in_fire)
            begin
                s1_valid_reg  <= 1'b1;
                // The RAM read issued now returns the old entry if the
                // working stage writes that same address in this cycle.
                l_byp_hit_reg <= l_we && (l_waddr == l_raddr_in);
                r_byp_hit_reg <= r_we && (r_waddr == r_raddr_in);
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            lvalid_reg <= lvalid_next;
            rvalid_reg <= rvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_op_reg      <= in_op;
            s1_dir_reg     <= s_axis_tdata[2];
            s1_key_reg     <= in_key;
            s1_partner_reg <= in_partner;
            l_byp_data_reg <= l_wdata;
            r_byp_data_reg <= r_wdata;
        end
        if (s1_go)
        begin
            out_found_reg  <= res_found;
            out_mapped_reg <= res_mapped;
            out_err_reg    <= res_err;
        end
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // The matching is one to one, so both tables hold as many pairs.
    `BIMT_ASSERT_NOW(a_pair_count, 1'b1, $countones(lvalid_reg) == $countones(rvalid_reg), "left and right tables disagree on the number of pairs")

    // Requests are refused only while a finished result waits to be taken.
    `BIMT_ASSERT_NOW(a_ready_stall, !s_axis_tready, out_valid_reg && !m_axis_tready && s1_valid_reg, "request refused without a stalled result")

    // A set in range leaves both indexes of the pair marked as mapped.
    `BIMT_ASSERT_NEXT(a_set_marks, s1_go && (s1_op_reg == OP_SET) && !res_err, lvalid_reg[$past(k_l)] && rvalid_reg[$past(p_r)], "set did not mark both entries of the pair")

endmodule

// ===== tb/bidirectional_index_matching_table_unit_tb.sv =====
// Self-checking testbench of the bidirectional index matching table unit.
module bidirectional_index_matching_table_unit_tb;
    import bimt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEFT_DEPTH  = 64;
    localparam int RIGHT_DEPTH = 64;

    // The fourth opcode has no name in the package; the block treats it as a no-operation.
    localparam logic [1:0] OP_NOP = 2'd3;

    // One result as the block packs it on m_axis_tdata.
    typedef struct packed {
        logic                 range_error;
        logic [IDX_W-1:0]     mapped_index;
        logic                 found;
    } match_result_t;

    // Mirror of both pairing tables and both size registers. Every accepted request is
    // applied to the mirror in acceptance order, and the result it must produce is queued.
    class match_scoreboard;
        bit               l2r_valid [LEFT_DEPTH];
        logic [IDX_W-1:0] l2r_idx   [LEFT_DEPTH];
        bit               r2l_valid [RIGHT_DEPTH];
        logic [IDX_W-1:0] r2l_idx   [RIGHT_DEPTH];
        logic [SIZE_W-1:0] left_size;
        logic [SIZE_W-1:0] right_size;
        match_result_t    expected_q [$];
        int               failures;

        function new();
            foreach (l2r_valid[i])
            begin
                l2r_valid[i] = 1'b0;
                l2r_idx[i]   = '0;
            end
            foreach (r2l_valid[i])
            begin
                r2l_valid[i] = 1'b0;
                r2l_idx[i]   = '0;
            end
            left_size  = SIZE_RESET;
            right_size = SIZE_RESET;
            failures   = 0;
        endfunction

        function void write_size(logic [CFG_IDX_W-1:0] index, logic [SIZE_W-1:0] value);
            if (index == REG_LEFT_SIZE)
                left_size = value;
            else
                right_size = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Breaking a pair clears the entry on both sides.
        function void unpair_left(int l);
            int r;
            if (l2r_valid[l])
            begin
                r = int'(l2r_idx[l]);
                l2r_valid[l] = 1'b0;
                l2r_idx[l]   = '0;
                r2l_valid[r] = 1'b0;
                r2l_idx[r]   = '0;
            end
        endfunction

        function void unpair_right(int r);
            int l;
            if (r2l_valid[r])
            begin
                l = int'(r2l_idx[r]);
                r2l_valid[r] = 1'b0;
                r2l_idx[r]   = '0;
                l2r_valid[l] = 1'b0;
                l2r_idx[l]   = '0;
            end
        endfunction

        function void note_request(logic [IN_DATA_W-1:0] data);
            logic [1:0]    opcode;
            logic          dir;
            int            key;
            int            partner;
            int            lb;
            int            rb;
            int            bound;
            match_result_t res;
            opcode  = data[1:0];
            dir     = data[2];
            key     = int'(data[8:3]);
            partner = int'(data[14:9]);
            // A size above the table depth acts as the depth.
            lb    = (int'(left_size) < LEFT_DEPTH) ? int'(left_size) : LEFT_DEPTH;
            rb    = (int'(right_size) < RIGHT_DEPTH) ? int'(right_size) : RIGHT_DEPTH;
            bound = (dir == DIR_LEFT) ? lb : rb;
            res   = '0;
            case (opcode)
                OP_SET:
                begin
                    // Set always pairs a left key with a right partner; direction is ignored.
                    if (key >= lb || partner >= rb)
                        res.range_error = 1'b1;
                    else if (!(l2r_valid[key] && int'(l2r_idx[key]) == partner))
                    begin
                        unpair_left(key);
                        unpair_right(partner);
                        l2r_valid[key]     = 1'b1;
                        l2r_idx[key]       = IDX_W'(partner);
                        r2l_valid[partner] = 1'b1;
                        r2l_idx[partner]   = IDX_W'(key);
                    end
                end
                OP_UNSET:
                begin
                    if (key >= bound)
                        res.range_error = 1'b1;
                    else if (dir == DIR_LEFT)
                        unpair_left(key);
                    else
                        unpair_right(key);
                end
                OP_GET:
                begin
                    if (key >= bound)
                        res.range_error = 1'b1;
                    else if (dir == DIR_LEFT && l2r_valid[key])
                    begin
                        res.found        = 1'b1;
                        res.mapped_index = l2r_idx[key];
                    end
                    else if (dir == DIR_RIGHT && r2l_valid[key])
                    begin
                        res.found        = 1'b1;
                        res.mapped_index = r2l_idx[key];
                    end
                end
                default:
                    ;
            endcase
            expected_q.push_back(res);
        endfunction

        function void report_mismatch(string field, logic [7:0] exp_val, logic [7:0] act_val);
            $error("%s: expected %0d, got %0d", field, exp_val, act_val);
            failures++;
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data);
            match_result_t act;
            match_result_t exp;
            act = data;
            if (expected_q.size() == 0)
            begin
                $error("result with no request waiting: tdata %h", data);
                failures++;
                return;
            end
            exp = expected_q.pop_front();
            if (act.found !== exp.found)
                report_mismatch("found", 8'(exp.found), 8'(act.found));
            if (act.mapped_index !== exp.mapped_index)
                report_mismatch("mapped_index", 8'(exp.mapped_index), 8'(act.mapped_index));
            if (act.range_error !== exp.range_error)
                report_mismatch("range_error", 8'(exp.range_error), 8'(act.range_error));
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // Bits from 0: opcode[1:0], direction[2], key[8:3], partner[14:9], zero[15].
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // Bits from 0: found[0], mapped_index[6:1], range_error[7].
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [SIZE_W-1:0]     cfg_wdata;

    // Percent of cycles in which the request side idles and the result side stalls.
    int sender_idle_pct = 0;
    int sink_stall_pct  = 0;

    match_scoreboard sb = new();

    bidirectional_index_matching_table_unit #(
        .LEFT_DEPTH  (LEFT_DEPTH),
        .RIGHT_DEPTH (RIGHT_DEPTH)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always #5 clk = ~clk;

    // The result side decides at each falling edge whether it takes a result at the next
    // rising edge, so stalls land on every phase of the block's pipeline.
    always @(negedge clk)
    begin
        m_axis_tready = ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Everything the block sees or produces is sampled at the rising edge, where the
    // testbench's own inputs, driven at the falling edge, are stable. Register writes are
    // mirrored first, although the stimulus never mixes them with requests.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_wr_en)
                sb.write_size(cfg_index, cfg_wdata);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_request(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
        end
    end

    // Offers one request, starting and ending at a falling edge. Between two back-to-back
    // requests tvalid simply stays high while the payload changes.
    task automatic send_request(logic [1:0] opcode, logic dir, int key, int partner);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {1'b0, partner[IDX_W-1:0], key[IDX_W-1:0], dir, opcode};
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    // Size registers are written only once the block has drained. Every request yields a
    // result, so the task waits until no result is pending before it writes.
    task automatic write_size_reg(logic [CFG_IDX_W-1:0] index, int value);
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = index;
        cfg_wdata = value[SIZE_W-1:0];
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    // Keys mostly fall inside the bound or right on it, so pairs collide often and the
    // range check is hit at its edge; now and then any 6-bit value is used.
    function automatic int pick_index(int size, int depth);
        int bound;
        bound = (size < depth) ? size : depth;
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(0, (bound > 63) ? 63 : bound);
        return $urandom_range(0, 63);
    endfunction

    task automatic send_random(int count, int lsize, int rsize);
        int         roll;
        logic       dir;
        logic [1:0] opcode;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            dir  = 1'($urandom_range(0, 1));
            if (roll < 35)
                opcode = OP_SET;
            else if (roll < 52)
                opcode = OP_UNSET;
            else if (roll < 92)
                opcode = OP_GET;
            else
                opcode = OP_NOP;
            if (opcode == OP_SET)
                send_request(opcode, dir, pick_index(lsize, LEFT_DEPTH),
                             pick_index(rsize, RIGHT_DEPTH));
            else if (dir == DIR_LEFT)
                send_request(opcode, dir, pick_index(lsize, LEFT_DEPTH), $urandom_range(0, 63));
            else
                send_request(opcode, dir, pick_index(rsize, RIGHT_DEPTH), $urandom_range(0, 63));
        end
    endtask

    // The run ends here if the block stops making progress.
    initial
    begin
        #5ms;
        $display("FAIL bidirectional_index_matching_table_unit");
        $finish;
    end

    initial
    begin
        // Random phases: a size setting and a request count each. The settings cover both
        // extremes (zero, where every key is out of range, and the all-ones value, which acts
        // as the full depth) as well as small and lopsided bounds.
        int phase_left  [8];
        int phase_right [8];
        int phase_count [8];

        phase_left    = '{64,  0, 127,   1,   8,  64,   3, 100};
        phase_right   = '{64,  0, 127,   1,   5,  16,  40,   7};
        phase_count   = '{210, 60, 210, 210, 210, 210, 210, 210};
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_wr_en     = 1'b0;
        cfg_index     = REG_LEFT_SIZE;
        cfg_wdata     = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part at the reset sizes, with no idling on either side. A get on an empty
        // table, a set that ignores its direction bit, a set that breaks two older pairs at
        // once, re-setting an existing pair, unset from the right side, unset of an unmapped
        // key, and the no-operation opcode with every field bit high.
        send_request(OP_GET,   DIR_LEFT,   0,  0);
        send_request(OP_SET,   DIR_RIGHT,  0, 63);
        send_request(OP_GET,   DIR_LEFT,   0,  0);
        send_request(OP_GET,   DIR_RIGHT, 63,  0);
        send_request(OP_SET,   DIR_LEFT,  63,  0);
        send_request(OP_SET,   DIR_LEFT,   0,  0);
        send_request(OP_GET,   DIR_LEFT,  63,  0);
        send_request(OP_GET,   DIR_RIGHT, 63,  0);
        send_request(OP_SET,   DIR_LEFT,   0,  0);
        send_request(OP_SET,   DIR_LEFT,  63, 63);
        send_request(OP_UNSET, DIR_RIGHT, 63, 63);
        send_request(OP_GET,   DIR_LEFT,  63,  0);
        send_request(OP_UNSET, DIR_LEFT,  63,  0);
        send_request(OP_NOP,   DIR_RIGHT, 63, 63);
        send_request(OP_SET,   DIR_LEFT,  42, 21);
        send_request(OP_GET,   DIR_RIGHT, 21,  0);
        send_request(OP_SET,   DIR_LEFT,   1, 60);

        // Shrink both bounds. Keys and partners on the bound must be refused without touching
        // the tables, while pairs made earlier survive: left key 1 still returns right index
        // 60 although that is far beyond the new right bound.
        write_size_reg(REG_LEFT_SIZE, 5);
        write_size_reg(REG_RIGHT_SIZE, 3);
        send_request(OP_SET,   DIR_LEFT,   5,  0);
        send_request(OP_SET,   DIR_LEFT,   0,  3);
        send_request(OP_UNSET, DIR_LEFT,   5,  0);
        send_request(OP_GET,   DIR_RIGHT,  3,  0);
        send_request(OP_GET,   DIR_LEFT,  42,  0);
        send_request(OP_GET,   DIR_RIGHT,  0,  0);
        send_request(OP_SET,   DIR_LEFT,   4,  2);
        send_request(OP_GET,   DIR_LEFT,   1,  0);

        // Random part. The idling pattern rotates through no idling, a mostly idle request
        // side, a mostly stalled result side, and light idling on both.
        for (int p = 0; p < 8; p++)
        begin
            write_size_reg(REG_LEFT_SIZE, phase_left[p]);
            write_size_reg(REG_RIGHT_SIZE, phase_right[p]);
            case (p % 4)
                0:
                begin
                    sender_idle_pct = 0;
                    sink_stall_pct  = 0;
                end
                1:
                begin
                    sender_idle_pct = 78;
                    sink_stall_pct  = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    sink_stall_pct  = 78;
                end
                default:
                begin
                    sender_idle_pct = 20;
                    sink_stall_pct  = 20;
                end
            endcase
            send_random(phase_count[p], phase_left[p], phase_right[p]);
        end

        // Drain: every request's result must arrive, then an extra wait shows whether the
        // block emits anything that was never asked for.
        s_axis_tvalid = 1'b0;
        sink_stall_pct = 0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        if (sb.failures == 0 && sb.pending() == 0)
            $display("PASS bidirectional_index_matching_table_unit");
        else
            $display("FAIL bidirectional_index_matching_table_unit");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/bimt_pkg.sv
hw/rtl/bimt_ram.sv
hw/rtl/bidirectional_index_matching_table_unit.sv
tb/bidirectional_index_matching_table_unit_tb.sv
